@@ hw/rtl/btc_pkg.sv @@
package btc_pkg;

  // Fixed widths of the row and of the size register.
  localparam int ROW_W         = 16;
  localparam int ROW_IDX_W     = 4;
  localparam int SIZE_W        = 5;
  localparam int MAX_NODES_DEF = 16;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd3;

  // Row store operations.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_MASK  = 3'd2;
  localparam logic [2:0] OP_PIVOT = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // One command from the sequencer to the row store.
  typedef struct packed {
    logic [2:0]           op;
    logic [ROW_IDX_W-1:0] addr;
    logic [ROW_W-1:0]     data;
  } store_cmd_t;

  // Mask with the low n bits set.
  function automatic logic [ROW_W-1:0] size_mask(input logic [SIZE_W-1:0] n);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (SIZE_W'(j) < n);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/btc_row_store.sv @@
module btc_row_store
  import btc_pkg::*;
#(
  parameter int CAP   = MAX_NODES_DEF,
  parameter int IDX_W = $clog2(CAP)
) (
  input  logic             clk,
  input  logic             rst,
  input  store_cmd_t       cmd,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] rows [CAP];

  // Single read port, shared by the pivot row and the emit path.
  assign rd_data = rows[rd_addr];

  // Mask, pivot and clear update all rows in parallel; the pivot pass ORs the pivot row into
  // every row that holds the pivot bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAP; i++) begin
        rows[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          rows[cmd.addr[IDX_W-1:0]] <= cmd.data;
        end
        OP_MASK: begin
          // A row at or beyond the size has its own mask bit clear.
          for (int i = 0; i < CAP; i++) begin
            rows[i] <= rows[i] & cmd.data & {ROW_W{cmd.data[i]}};
          end
        end
        OP_PIVOT: begin
          for (int i = 0; i < CAP; i++) begin
            if (rows[i][cmd.addr]) begin
              rows[i] <= rows[i] | rd_data;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < CAP; i++) begin
            rows[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/boolean_relation_transitive_closure.sv @@
// Transitive closure of a boolean relation, loaded one row per beat.
// Load: one row beat per cycle while idle. After the beat with tlast the block
// runs a mask step, one pivot pass per row over the shared row port and a fetch
// step, then emits n rows at up to one beat per cycle.
// Reset (synchronous, active high) clears the row store and sets the size to 3.
module boolean_relation_transitive_closure
  import btc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] row_bits
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // [3:0] row_index, [19:4] closure_bits, rest zero
  output logic              m_tlast
);

  localparam int CAP   = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [SIZE_W-1:0] CAP_S = SIZE_W'(CAP);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MASK  = 3'd1;
  localparam logic [2:0] S_PIVOT = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]           state;
  logic [SIZE_W-1:0]    size_in_use;
  logic [SIZE_W-1:0]    n_eff;
  logic [SIZE_W-1:0]    size_clamped;
  logic [CNT_W-1:0]     rows_loaded;
  logic [IDX_W-1:0]     k_cnt;
  logic [IDX_W-1:0]     emit_idx;
  logic [ROW_IDX_W-1:0] out_row_idx;
  logic [ROW_W-1:0]     out_bits;
  logic [IDX_W-1:0]     rd_addr;
  logic [ROW_W-1:0]     rd_data;
  logic [SIZE_W-1:0]    next_row;
  logic                 in_beat;
  logic                 out_beat;
  logic                 room;
  store_cmd_t           cmd;

  assign s_tready = (state == S_LOAD);
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign room     = (rows_loaded < CNT_W'(CAP));
  assign next_row = SIZE_W'(emit_idx) + SIZE_W'(1);
  assign m_tdata  = {4'b0000, out_bits, out_row_idx};

  // Size clamped to the range 1 to the row capacity.
  always_comb begin
    if (size_in_use == '0) begin
      size_clamped = SIZE_W'(1);
    end else if (size_in_use > CAP_S) begin
      size_clamped = CAP_S;
    end else begin
      size_clamped = size_in_use;
    end
  end

  // Read address: pivot row while pivoting, else the row to emit next.
  always_comb begin
    case (state)
      S_PIVOT: rd_addr = k_cnt;
      S_FIRST: rd_addr = '0;
      default: rd_addr = emit_idx + IDX_W'(1);
    endcase
  end

  // Commands to the row store.
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.addr = '0;
    cmd.data = '0;
    case (state)
      S_LOAD: begin
        if (in_beat && room) begin
          cmd.op   = OP_LOAD;
          cmd.addr = ROW_IDX_W'(rows_loaded[IDX_W-1:0]);
          cmd.data = s_tdata;
        end
      end
      S_MASK: begin
        cmd.op   = OP_MASK;
        cmd.data = size_mask(n_eff);
      end
      S_PIVOT: begin
        cmd.op   = OP_PIVOT;
        cmd.addr = ROW_IDX_W'(k_cnt);
      end
      S_EMIT: begin
        if (out_beat && m_tlast) begin
          cmd.op = OP_CLEAR;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_in_use <= cfg_wr_data;
    end
  end

  // Sequencer: load rows, mask, pivot passes, then emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      rows_loaded <= '0;
      n_eff       <= SIZE_W'(1);
      k_cnt       <= '0;
      emit_idx    <= '0;
      m_tvalid    <= 1'b0;
      m_tlast     <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_beat) begin
            if (room) begin
              rows_loaded <= rows_loaded + CNT_W'(1);
            end
            if (s_tlast) begin
              n_eff <= size_clamped;
              state <= S_MASK;
            end
          end
        end
        S_MASK: begin
          k_cnt <= '0;
          state <= S_PIVOT;
        end
        S_PIVOT: begin
          if (SIZE_W'(k_cnt) == n_eff - SIZE_W'(1)) begin
            state <= S_FIRST;
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        S_FIRST: begin
          emit_idx <= '0;
          m_tvalid <= 1'b1;
          m_tlast  <= (n_eff == SIZE_W'(1));
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_beat) begin
            if (m_tlast) begin
              m_tvalid    <= 1'b0;
              m_tlast     <= 1'b0;
              rows_loaded <= '0;
              state       <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + IDX_W'(1);
              m_tlast  <= (next_row + SIZE_W'(1) == n_eff);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (state == S_FIRST) begin
      out_bits    <= rd_data;
      out_row_idx <= '0;
    end else if (state == S_EMIT && out_beat && !m_tlast) begin
      out_bits    <= rd_data;
      out_row_idx <= ROW_IDX_W'(next_row);
    end
  end

  btc_row_store #(
    .CAP   (CAP),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
